// ===== hw/rtl/haversine_distance_assert.svh =====
// Assertion macros shared by the haversine distance checker.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef HAVERSINE_DISTANCE_ASSERT_SVH
`define HAVERSINE_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hvd_pkg.sv =====
// Package for the haversine distance block: widths, fixed-point constants
// and the CORDIC arctangent table. Used by haversine_distance, hvd_rot and hvd_vec.
package hvd_pkg;

	// Signed width of CORDIC x, y and z datapaths (Q30 values with headroom).
	localparam int CW = 35;
	// Register stages of the degree-to-radian division after the product.
	localparam int DIV_STAGES = 3;
	// Number of result bits of the square root.
	localparam int SQ_BITS = 31;
	// Width of the square root radicand (h in Q30 shifted up by 30).
	localparam int SQ_W = 61;

	localparam logic [32:0] PI_Q31 = 33'd6746518852;
	localparam logic [32:0] FULL_DIV = 33'd3600000000;
	localparam logic [32:0] HALF_DIV = 33'd7200000000;
	// Both divisors are this odd factor times 2^10 and 2^11.
	localparam logic [23:0] RAD_ODD = 24'd3515625;
	// floor(2^54 / RAD_ODD), used to estimate the quotient.
	localparam logic [32:0] RAD_RECIP = 33'd5124095576;
	localparam logic signed [CW-1:0] GAIN_Q30 = 35'sd652032874;
	localparam logic signed [CW-1:0] ONE_Q30 = 35'sd1073741824;
	localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
	localparam logic signed [33:0] TURN = 34'sd3600000000;
	localparam logic signed [33:0] HALF_TURN = 34'sd1800000000;
	localparam logic [32:0] RADIUS_RESET = 33'd6371008800;
	localparam logic [34:0] DIST_MAX = 35'd27000000000;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic signed [CW-1:0] r;
		case (i)
			0: r = 35'sd843314857;
			1: r = 35'sd497837829;
			2: r = 35'sd263043837;
			3: r = 35'sd133525159;
			4: r = 35'sd67021687;
			5: r = 35'sd33543516;
			6: r = 35'sd16775851;
			7: r = 35'sd8388437;
			8: r = 35'sd4194283;
			9: r = 35'sd2097149;
			default: begin
				if (i <= 30) begin
					r = CW'(64'sd1 <<< (30 - i));
				end else begin
					r = '0;
				end
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/haversine_distance.sv =====
// Haversine great-circle distance. Each request carries two positions
// (latitude and longitude in signed units of 1e-7 degree) and yields one
// distance in millimetres, scaled by the programmable sphere radius and
// saturated at 27000000000. The block is a single stall-able pipeline: it
// accepts one request per clock while the output is not stalled. The depth
// of the pipeline is set by the degree-to-radian conversion (a product, a
// reciprocal estimate of the quotient, a remainder and a final correction,
// four stages), the two CORDIC chains (CORDIC_STEPS stages each), the
// bit-per-stage square roots (31 stages) and the product, sum and scaling
// stages around them.
// When the result at the output is not taken, the whole pipeline holds;
// while the output register is empty or being drained, in_ready stays high.
// The radius register may only be written while no request is in flight.
module haversine_distance #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [30:0] lat_a,
	input  logic signed [31:0] lon_a,
	input  logic signed [30:0] lat_b,
	input  logic signed [31:0] lon_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [34:0] distance_mm,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [32:0] earth_radius_mm
);

	localparam int CW = hvd_pkg::CW;
	localparam int DS = hvd_pkg::DIV_STAGES;
	localparam int SB = hvd_pkg::SQ_BITS;
	localparam int SW = hvd_pkg::SQ_W;
	// Total pipeline depth, from the input register to the output register.
	localparam int LAT = 2 + DS + CORDIC_STEPS + 3 + SB + CORDIC_STEPS + 2;

	// Q30 product with rounding half up, arithmetic shift.
	function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [2*CW-1:0] p;
		p = (2*CW)'(a) * (2*CW)'(b) + (2*CW)'(64'sd536870912);
		return CW'(p >>> 30);
	endfunction

	logic             en;
	logic [LAT-1:0]   vld_q;
	logic [32:0]      radius_q;

	// The whole pipeline moves when the output register is free or drained.
	assign en        = !vld_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hvd_pkg::RADIUS_RESET;
		end else if (cfg_valid) begin
			radius_q <= earth_radius_mm;
		end
	end

	// Stage 1: clamp latitudes, form differences, wrap the longitude
	// difference into half a turn either side, and take magnitudes.
	// Lanes: 0 half dlat, 1 half dlon, 2 lat_a, 3 lat_b.
	logic signed [30:0] lat_a_c, lat_b_c;
	logic signed [31:0] dlat;
	logic signed [33:0] dlon_raw, dlon_mod, dlon_w;
	logic        [30:0] mag_s1 [4];

	always_comb begin
		lat_a_c = lat_a;
		if (lat_a > hvd_pkg::LAT_LIMIT) begin
			lat_a_c = hvd_pkg::LAT_LIMIT;
		end else if (lat_a < -hvd_pkg::LAT_LIMIT) begin
			lat_a_c = -hvd_pkg::LAT_LIMIT;
		end
		lat_b_c = lat_b;
		if (lat_b > hvd_pkg::LAT_LIMIT) begin
			lat_b_c = hvd_pkg::LAT_LIMIT;
		end else if (lat_b < -hvd_pkg::LAT_LIMIT) begin
			lat_b_c = -hvd_pkg::LAT_LIMIT;
		end
		dlat = 32'(lat_b_c) - 32'(lat_a_c);
		dlon_raw = 34'(lon_b) - 34'(lon_a);
		// Truncating remainder by a full turn; the difference is below two turns.
		dlon_mod = dlon_raw;
		if (dlon_raw >= hvd_pkg::TURN) begin
			dlon_mod = dlon_raw - hvd_pkg::TURN;
		end else if (dlon_raw <= -hvd_pkg::TURN) begin
			dlon_mod = dlon_raw + hvd_pkg::TURN;
		end
		dlon_w = dlon_mod;
		if (dlon_mod > hvd_pkg::HALF_TURN) begin
			dlon_w = dlon_mod - hvd_pkg::TURN;
		end else if (dlon_mod < -hvd_pkg::HALF_TURN) begin
			dlon_w = dlon_mod + hvd_pkg::TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1[0] <= dlat[31] ? 31'(-dlat) : dlat[30:0];
			mag_s1[1] <= dlon_w[33] ? 31'(-dlon_w) : dlon_w[30:0];
			mag_s1[2] <= lat_a_c[30] ? 31'(-lat_a_c) : lat_a_c;
			mag_s1[3] <= lat_b_c[30] ? 31'(-lat_b_c) : lat_b_c;
		end
	end

	// Stages 2 to 5: radians = round(mag * pi_q31 / divisor). The divisor is an
	// odd factor times a power of two, so the numerator is shifted down first.
	// A reciprocal multiply on the top 32 bits gives a quotient at most three
	// below the true one; the remainder then selects the final correction.
	logic signed [CW-1:0] s_lat, s_lon, c_a, c_b;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam logic [32:0] DIVISOR = (l < 2) ? hvd_pkg::HALF_DIV : hvd_pkg::FULL_DIV;
		localparam int DSH = (l < 2) ? 11 : 10;
		localparam logic [23:0] ODD2 = 24'(2 * hvd_pkg::RAD_ODD);
		localparam logic [23:0] ODD3 = 24'(3 * hvd_pkg::RAD_ODD);
		logic [63:0] num_s2;
		logic [31:0] num_hi;
		logic [53:0] np_s3;
		logic [30:0] est_s3, est_s4, quo_s5;
		logic [53:0] back;
		logic [23:0] rem_s4;
		logic [1:0]  fix;
		logic signed [CW-1:0] sin_l, cos_l;

		assign num_hi = 32'(num_s2 >> (DSH + 22));
		assign back   = 54'(est_s3) * 54'(hvd_pkg::RAD_ODD);

		always_comb begin
			fix = 2'd0;
			if (rem_s4 >= ODD3) begin
				fix = 2'd3;
			end else if (rem_s4 >= ODD2) begin
				fix = 2'd2;
			end else if (rem_s4 >= hvd_pkg::RAD_ODD) begin
				fix = 2'd1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s2 <= 64'(mag_s1[l]) * 64'(hvd_pkg::PI_Q31) + 64'(DIVISOR >> 1);
				np_s3  <= 54'(num_s2 >> DSH);
				est_s3 <= 31'((65'(num_hi) * 65'(hvd_pkg::RAD_RECIP)) >> 32);
				rem_s4 <= 24'(np_s3 - back);
				est_s4 <= est_s3;
				quo_s5 <= est_s4 + 31'(fix);
			end
		end

		hvd_rot #(
			.CORDIC_STEPS(CORDIC_STEPS)
		) u_rot (
			.clk    (clk),
			.en     (en),
			.z_in   (CW'(quo_s5)),
			.cos_out(cos_l),
			.sin_out(sin_l)
		);

		if (l == 0) begin : g_slat
			assign s_lat = sin_l;
		end else if (l == 1) begin : g_slon
			assign s_lon = sin_l;
		end else if (l == 2) begin : g_ca
			assign c_a = cos_l;
		end else begin : g_cb
			assign c_b = cos_l;
		end
	end

	// Products: two squares and the cross term, then the final product, then
	// the clamped sum h and the radicands for both square roots.
	logic signed [CW-1:0] p_lat_s1, p_cc_s1, p_lon_s1;
	logic signed [CW-1:0] p_lat_s2, p_cross_s2;
	logic signed [CW-1:0] h_sum;
	logic signed [CW-1:0] h_c;

	always_ff @(posedge clk) begin
		if (en) begin
			p_lat_s1   <= mulq(s_lat, s_lat);
			p_cc_s1    <= mulq(c_a, c_b);
			p_lon_s1   <= mulq(s_lon, s_lon);
			p_lat_s2   <= p_lat_s1;
			p_cross_s2 <= mulq(p_cc_s1, p_lon_s1);
		end
	end

	always_comb begin
		h_sum = p_lat_s2 + p_cross_s2;
		h_c = h_sum;
		if (h_sum < 0) begin
			h_c = '0;
		end else if (h_sum > hvd_pkg::ONE_Q30) begin
			h_c = hvd_pkg::ONE_Q30;
		end
	end

	// Square roots, one result bit per stage. Lane 0 is sqrt(h), lane 1 is
	// sqrt(1 - h); both radicands are Q30 values shifted up by 30.
	logic [SW-1:0] sqn_s [2][SB+1];
	logic [SW-1:0] sqr_s [2][SB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sqn_s[0][0] <= SW'(h_c[30:0]) << 30;
			sqn_s[1][0] <= SW'(30'(hvd_pkg::ONE_Q30 - h_c) | (31'(hvd_pkg::ONE_Q30 - h_c)
				& 31'h40000000) << 0) << 30;
			sqr_s[0][0] <= '0;
			sqr_s[1][0] <= '0;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_sq
		for (genvar j = 0; j < SB; j++) begin : g_bit
			localparam int SH = 2 * (SB - 1 - j);
			logic [SW:0] trial;
			logic [SW-1:0] bitv;
			assign bitv  = SW'(1) << SH;
			assign trial = (SW+1)'(sqr_s[l][j]) + (SW+1)'(bitv);
			always_ff @(posedge clk) begin
				if (en) begin
					if ((SW+1)'(sqn_s[l][j]) >= trial) begin
						sqn_s[l][j+1] <= sqn_s[l][j] - SW'(trial);
						sqr_s[l][j+1] <= (sqr_s[l][j] >> 1) + bitv;
					end else begin
						sqn_s[l][j+1] <= sqn_s[l][j];
						sqr_s[l][j+1] <= sqr_s[l][j] >> 1;
					end
				end
			end
		end
	end

	// Central half-angle: atan2(sqrt(h), sqrt(1 - h)).
	logic signed [CW-1:0] ang;

	hvd_vec #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_vec (
		.clk    (clk),
		.en     (en),
		.x_in   (CW'(sqr_s[1][SB][30:0])),
		.y_in   (CW'(sqr_s[0][SB][30:0])),
		.ang_out(ang)
	);

	// Scale by the radius: the shift by 29 folds in the factor of two.
	logic [63:0] prod_s1;
	logic [63:0] scaled;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ang[CW-1] ? '0 : 64'(ang[30:0]) * 64'(radius_q);
		end
	end

	assign scaled = (prod_s1 + 64'(1 << 28)) >> 29;

	always_ff @(posedge clk) begin
		if (en) begin
			distance_mm <= (scaled > 64'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX
				: scaled[34:0];
		end
	end

endmodule

// ===== hw/rtl/hvd_rot.sv =====
// Rotation-mode CORDIC pipeline giving sine and cosine of a Q30 angle.
// One register stage per iteration; depends on hvd_pkg.
module hvd_rot #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [hvd_pkg::CW-1:0] z_in,
	output logic signed [hvd_pkg::CW-1:0] cos_out,
	output logic signed [hvd_pkg::CW-1:0] sin_out
);

	logic signed [hvd_pkg::CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [hvd_pkg::CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [hvd_pkg::CW-1:0] z_s [CORDIC_STEPS+1];

	assign x_s[0] = hvd_pkg::GAIN_Q30;
	assign y_s[0] = '0;
	assign z_s[0] = z_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [hvd_pkg::CW-1:0] dx, dy, at;
		assign dx = x_s[i] >>> 0;
		assign dy = y_s[i] >>> i;
		assign at = hvd_pkg::atan_q30(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][hvd_pkg::CW-1]) begin
					x_s[i+1] <= x_s[i] - dy;
					y_s[i+1] <= y_s[i] + (dx >>> i);
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dy;
					y_s[i+1] <= y_s[i] - (dx >>> i);
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	assign cos_out = x_s[CORDIC_STEPS];
	assign sin_out = y_s[CORDIC_STEPS];

endmodule

// ===== hw/rtl/hvd_vec.sv =====
// Vectoring-mode CORDIC pipeline giving the angle of the vector (x, y).
// One register stage per iteration; depends on hvd_pkg.
module hvd_vec #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [hvd_pkg::CW-1:0] x_in,
	input  logic signed [hvd_pkg::CW-1:0] y_in,
	output logic signed [hvd_pkg::CW-1:0] ang_out
);

	logic signed [hvd_pkg::CW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [hvd_pkg::CW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [hvd_pkg::CW-1:0] z_s [CORDIC_STEPS+1];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = '0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [hvd_pkg::CW-1:0] dx, dy, at;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = hvd_pkg::atan_q30(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end else if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					// A vector already on the axis stays where it is.
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end
			end
		end
	end

	assign ang_out = z_s[CORDIC_STEPS];

endmodule

// ===== hw/rtl/hvd_checker.sv =====
// Port-level checker for the haversine distance block, bound to its top.
// Depends on haversine_distance_assert.svh for the assertion macros.
`include "haversine_distance_assert.svh"

module hvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [34:0] distance_mm,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	`HVD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance_mm), "result changed while stalled")
	`HVD_ASSERT_NOW(a_dist_range, out_valid, distance_mm <= 35'd27000000000, "distance above saturation limit")
	`HVD_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready, "input refused while output register is free")
	`HVD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "radius write refused")

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);
